FILE: hw/rtl/chte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants for the chained hash table engine
// Table geometry, request kinds, result status codes and the word layouts
// passed between the front end, the request queue and the back end.
// ----------------------------------------------------------------------------
package chte_pkg;

   // table geometry
   localparam int BUCKETS   = 9;
   localparam int ENTRIES   = 32;
   localparam int KEY_CHARS = 8;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int LINK_W = SLOT_W + 1;
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int BCNT_W = $clog2(BUCKETS + 1);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   localparam logic [LINK_W-1:0] END_MARK = '1;

   // bucket modulo by reciprocal multiply (average is below 256)
   localparam int MOD_SHIFT = 16;
   localparam int MOD_MULT  = ((1 << MOD_SHIFT) + BUCKETS - 1) / BUCKETS;

   // request kinds
   localparam logic [1:0] K_INSERT = 2'd0;
   localparam logic [1:0] K_DELETE = 2'd1;
   localparam logic [1:0] K_SEARCH = 2'd2;
   localparam logic [1:0] K_LIST   = 2'd3;

   // result status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_KEY   = 3'd4;

   // normalized request, front to back
   typedef struct packed {
      logic [1:0]       kind;
      logic [63:0]      key;
      logic [3:0]       key_length;
      logic [39:0]      phone;
      logic [15:0]      code;
      logic             bad;
      logic [BKT_W-1:0] bucket;
   } cmd_type;

   // one stored record
   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [39:0] phone;
      logic [15:0] code;
   } ent_type;

   // result word, status in the low bits
   typedef struct packed {
      logic [63:0] found_key;
      logic [15:0] found_code;
      logic [39:0] found_phone;
      logic [4:0]  location;
      logic [2:0]  status;
   } rsp_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'd32;
      end
      return c;
   endfunction

   // link of a slot that was never written: reset free list order
   function automatic logic [LINK_W-1:0] link_reset(input logic [SLOT_W-1:0] slot);
      if (int'(slot) == ENTRIES - 1) begin
         return END_MARK;
      end
      return LINK_W'(slot) + LINK_W'(1);
   endfunction

endpackage

FILE: hw/rtl/chte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_front: request intake and key classification
// Clamps the key length, masks unused key bytes, forms the bucket average
// and its remainder over the bucket count, and flags bad keys. Two stages.
// ----------------------------------------------------------------------------
module chte_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // kind[1:0]
   input  logic [1:0]             req_tuser,
   // key[63:0], key_length[67:64], phone[107:68], code[123:108]
   input  logic [127:0]           req_tdata,
   output logic                   q_valid,
   input  logic                   q_ready,
   output chte_pkg::cmd_type      q_data
);

   logic [1:0]  in_kind;
   logic [63:0] in_key;
   logic [3:0]  in_klen;
   logic [3:0]  len_c;
   logic [63:0] key_m;
   logic [7:0]  first_c;
   logic [7:0]  last_c;
   logic signed [9:0] sum_c;
   logic        bad_c;
   logic [7:0]  avg_c;

   logic        advance;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   chte_pkg::cmd_type s1_ff, s2_ff;
   logic [7:0]  avg1_ff, avg2_ff;
   logic [7:0]  quo_ff;
   logic [25:0] prod_c;
   logic [13:0] rem_c;

   assign in_kind = req_tuser;
   assign in_key  = req_tdata[63:0];
   assign in_klen = req_tdata[67:64];

   // length clamp, key byte mask, last character pick
   always_comb begin
      if (in_klen == 4'd0) begin
         len_c = 4'd1;
      end else if (in_klen > 4'(chte_pkg::KEY_CHARS)) begin
         len_c = 4'(chte_pkg::KEY_CHARS);
      end else begin
         len_c = in_klen;
      end
      last_c = in_key[7:0];
      for (int i = 0; i < 8; i++) begin
         key_m[8*i +: 8] = (4'(i) < len_c) ? in_key[8*i +: 8] : 8'd0;
         if (4'(i + 1) == len_c) begin
            last_c = in_key[8*i +: 8];
         end
      end
      first_c = chte_pkg::upcase(in_key[7:0]);
      sum_c = $signed({2'b00, first_c}) + $signed({2'b00, chte_pkg::upcase(last_c)})
              - 10'sd128;
      // average truncates toward zero: only a sum below -1 goes negative
      bad_c = (sum_c < -10'sd1);
      avg_c = sum_c[9] ? 8'd0 : sum_c[8:1];
   end

   assign advance    = !s2_valid_ff || q_ready;
   assign req_tready = advance;

   assign s1_valid_in = advance ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // quotient estimate by reciprocal
   assign prod_c = 26'(avg1_ff) * 26'(chte_pkg::MOD_MULT);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.kind       <= in_kind;
         s1_ff.key        <= key_m;
         s1_ff.key_length <= len_c;
         s1_ff.phone      <= req_tdata[107:68];
         s1_ff.code       <= req_tdata[123:108];
         s1_ff.bad        <= bad_c;
         s1_ff.bucket     <= '0;
         avg1_ff          <= avg_c;
         s2_ff            <= s1_ff;
         avg2_ff          <= avg1_ff;
         quo_ff           <= 8'(prod_c >> chte_pkg::MOD_SHIFT);
      end
   end

   // remainder with one correction step
   always_comb begin
      rem_c = 14'(avg2_ff) - 14'(quo_ff) * 14'(chte_pkg::BUCKETS);
      if (rem_c >= 14'(chte_pkg::BUCKETS)) begin
         rem_c = rem_c - 14'(chte_pkg::BUCKETS);
      end
      q_data        = s2_ff;
      q_data.bucket = chte_pkg::BKT_W'(rem_c);
   end

   assign q_valid = s2_valid_ff;

endmodule

FILE: hw/rtl/chte_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_queue: two-entry request queue
// Decouples the front end from the back end so either side can stall.
// ----------------------------------------------------------------------------
module chte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  chte_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output chte_pkg::cmd_type out_data
);

   chte_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: hw/rtl/chte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_back: table sequencer
// Walks bucket chains through the record and link memories, updates the
// chains and the free-slot stack, and drives the registered result word.
// ----------------------------------------------------------------------------
module chte_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  chte_pkg::cmd_type cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata,
   output logic              rsp_tlast
);

   localparam int LW = chte_pkg::LINK_W;
   localparam int SW = chte_pkg::SLOT_W;
   localparam int NE = chte_pkg::ENTRIES;
   localparam int NB = chte_pkg::BUCKETS;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FCHK  = 4'd1;
   localparam logic [3:0] S_FCMP  = 4'd2;
   localparam logic [3:0] S_IWR   = 4'd3;
   localparam logic [3:0] S_ILNK  = 4'd4;
   localparam logic [3:0] S_DLNK  = 4'd5;
   localparam logic [3:0] S_DFREE = 4'd6;
   localparam logic [3:0] S_LHEAD = 4'd7;
   localparam logic [3:0] S_LCHK  = 4'd8;
   localparam logic [3:0] S_LCMP  = 4'd9;
   localparam logic [3:0] S_LEND  = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;

   function automatic chte_pkg::rsp_type mk_rsp(input logic [2:0] st,
                                                input logic [LW-1:0] slot,
                                                input chte_pkg::ent_type e);
      chte_pkg::rsp_type r;
      r.status      = st;
      r.location    = 5'(slot);
      r.found_phone = e.phone;
      r.found_code  = e.code;
      r.found_key   = e.key;
      return r;
   endfunction

   function automatic chte_pkg::rsp_type no_rsp(input logic [2:0] st);
      chte_pkg::rsp_type r;
      r        = '0;
      r.status = st;
      return r;
   endfunction

   logic [3:0]    state_ff, state_in;
   chte_pkg::cmd_type cur_ff, cur_in;
   logic [LW-1:0] p_ff, p_in;
   logic [LW-1:0] pred_ff, pred_in;
   logic [LW-1:0] next_ff, next_in;
   logic [chte_pkg::CNT_W-1:0]  steps_ff, steps_in;
   logic [chte_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [chte_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [chte_pkg::BCNT_W-1:0] lb_ff, lb_in;
   logic [LW-1:0] head_ff [NB];
   logic [LW-1:0] head_in [NB];
   logic [LW-1:0] free_top_ff, free_top_in;
   logic [NE-1:0] lvalid_ff, lvalid_in;
   chte_pkg::rsp_type res_ff, res_in;
   chte_pkg::rsp_type pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   chte_pkg::rsp_type out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_last_ff, out_last_in;

   // memories and their read registers
   chte_pkg::ent_type ent_mem [NE];
   logic [LW-1:0] link_mem [NE];
   chte_pkg::ent_type ent_rd_ff;
   logic [LW-1:0] link_rd_ff;
   logic          lv_rd_ff;
   logic [SW-1:0] raddr_ff;

   logic          rd_en;
   logic [SW-1:0] rd_addr;
   logic          ent_we;
   logic [SW-1:0] ent_wa;
   chte_pkg::ent_type ent_wd;
   logic          link_we;
   logic [SW-1:0] link_wa;
   logic [LW-1:0] link_wd;

   logic [chte_pkg::BKT_W-1:0] hidx;
   logic [LW-1:0] head_rd;
   logic [LW-1:0] link_val;
   logic          out_free;
   logic          key_hit;
   chte_pkg::ent_type new_ent;

   assign hidx     = (state_ff == S_IDLE) ? cmd.bucket : lb_ff[chte_pkg::BKT_W-1:0];
   assign head_rd  = head_ff[hidx];
   assign link_val = lv_rd_ff ? link_rd_ff : chte_pkg::link_reset(raddr_ff);
   assign out_free = !out_valid_ff || rsp_tready;
   assign key_hit  = (ent_rd_ff.key_length == cur_ff.key_length) &&
                     (ent_rd_ff.key == cur_ff.key);

   assign new_ent.key        = cur_ff.key;
   assign new_ent.key_length = cur_ff.key_length;
   assign new_ent.phone      = cur_ff.phone;
   assign new_ent.code       = cur_ff.code;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      p_in          = p_ff;
      pred_in       = pred_ff;
      next_in       = next_ff;
      steps_in      = steps_ff;
      n_in          = n_ff;
      count_in      = count_ff;
      lb_in         = lb_ff;
      head_in       = head_ff;
      free_top_in   = free_top_ff;
      lvalid_in     = lvalid_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = rsp_tready ? 1'b0 : out_valid_ff;
      cmd_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = SW'(p_ff);
      ent_we        = 1'b0;
      ent_wa        = SW'(free_top_ff);
      ent_wd        = new_ent;
      link_we       = 1'b0;
      link_wa       = SW'(pred_ff);
      link_wd       = next_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               cur_in    = cmd;
               if (cmd.kind == chte_pkg::K_LIST) begin
                  lb_in         = '0;
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_LHEAD;
               end else if (cmd.kind == chte_pkg::K_INSERT &&
                            (count_ff >= chte_pkg::CNT_W'(NE) ||
                             free_top_ff >= LW'(NE))) begin
                  res_in   = no_rsp(chte_pkg::ST_FULL);
                  state_in = S_EMIT;
               end else if (cmd.bad) begin
                  res_in   = no_rsp(chte_pkg::ST_BAD_KEY);
                  state_in = S_EMIT;
               end else begin
                  p_in     = head_rd;
                  pred_in  = chte_pkg::END_MARK;
                  steps_in = '0;
                  state_in = S_FCHK;
               end
            end
         end
         S_FCHK: begin
            if (p_ff >= LW'(NE) || steps_ff == chte_pkg::CNT_W'(NE)) begin
               if (cur_ff.kind == chte_pkg::K_INSERT) begin
                  // fetch the link of the free-stack top
                  rd_en    = 1'b1;
                  rd_addr  = SW'(free_top_ff);
                  state_in = S_IWR;
               end else begin
                  res_in   = no_rsp(chte_pkg::ST_NOT_FOUND);
                  state_in = S_EMIT;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_FCMP;
            end
         end
         S_FCMP: begin
            if (key_hit) begin
               if (cur_ff.kind == chte_pkg::K_INSERT) begin
                  res_in   = mk_rsp(chte_pkg::ST_DUPLICATE, p_ff, ent_rd_ff);
                  state_in = S_EMIT;
               end else if (cur_ff.kind == chte_pkg::K_DELETE) begin
                  res_in   = mk_rsp(chte_pkg::ST_OK, p_ff, ent_rd_ff);
                  next_in  = link_val;
                  state_in = S_DLNK;
               end else begin
                  res_in   = mk_rsp(chte_pkg::ST_OK, p_ff, ent_rd_ff);
                  state_in = S_EMIT;
               end
            end else begin
               pred_in  = p_ff;
               p_in     = link_val;
               steps_in = steps_ff + chte_pkg::CNT_W'(1);
               state_in = S_FCHK;
            end
         end
         S_IWR: begin
            // pop free slot, store record, terminate it
            free_top_in = link_val;
            count_in    = count_ff + chte_pkg::CNT_W'(1);
            ent_we      = 1'b1;
            link_we     = 1'b1;
            link_wa     = SW'(free_top_ff);
            link_wd     = chte_pkg::END_MARK;
            lvalid_in[SW'(free_top_ff)] = 1'b1;
            next_in     = free_top_ff;
            res_in      = mk_rsp(chte_pkg::ST_OK, free_top_ff, new_ent);
            if (pred_ff < LW'(NE)) begin
               state_in = S_ILNK;
            end else begin
               head_in[cur_ff.bucket] = free_top_ff;
               state_in = S_EMIT;
            end
         end
         S_ILNK: begin
            link_we   = 1'b1;
            lvalid_in[SW'(pred_ff)] = 1'b1;
            state_in  = S_EMIT;
         end
         S_DLNK: begin
            // unlink the found slot
            if (pred_ff < LW'(NE)) begin
               link_we = 1'b1;
               lvalid_in[SW'(pred_ff)] = 1'b1;
            end else begin
               head_in[cur_ff.bucket] = next_ff;
            end
            state_in = S_DFREE;
         end
         S_DFREE: begin
            // push it on the free stack
            link_we     = 1'b1;
            link_wa     = SW'(p_ff);
            link_wd     = free_top_ff;
            lvalid_in[SW'(p_ff)] = 1'b1;
            free_top_in = p_ff;
            if (count_ff != '0) begin
               count_in = count_ff - chte_pkg::CNT_W'(1);
            end
            state_in = S_EMIT;
         end
         S_LHEAD: begin
            if (lb_ff == chte_pkg::BCNT_W'(NB)) begin
               state_in = S_LEND;
            end else begin
               p_in     = head_rd;
               steps_in = '0;
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (p_ff >= LW'(NE) || steps_ff == chte_pkg::CNT_W'(NE) ||
                n_ff == chte_pkg::CNT_W'(NE)) begin
               lb_in    = lb_ff + chte_pkg::BCNT_W'(1);
               state_in = S_LHEAD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_LCMP;
            end
         end
         S_LCMP: begin
            // one match is held back so the final one can carry last
            if (ent_rd_ff.code == cur_ff.code) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = pend_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_in       = mk_rsp(chte_pkg::ST_OK, p_ff, ent_rd_ff);
                  pend_valid_in = 1'b1;
                  n_in          = n_ff + chte_pkg::CNT_W'(1);
                  p_in          = link_val;
                  steps_in      = steps_ff + chte_pkg::CNT_W'(1);
                  state_in      = S_LCHK;
               end
            end else begin
               p_in     = link_val;
               steps_in = steps_ff + chte_pkg::CNT_W'(1);
               state_in = S_LCHK;
            end
         end
         S_LEND: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_valid_ff ? pend_ff : no_rsp(chte_pkg::ST_NOT_FOUND);
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         free_top_ff   <= '0;
         lvalid_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            head_ff[i] <= chte_pkg::END_MARK;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         free_top_ff   <= free_top_in;
         lvalid_ff     <= lvalid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         head_ff       <= head_in;
      end
   end

   // walk registers and payload
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      p_ff        <= p_in;
      pred_ff     <= pred_in;
      next_ff     <= next_in;
      steps_ff    <= steps_in;
      n_ff        <= n_in;
      lb_ff       <= lb_in;
      res_ff      <= res_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // record and link memories, registered read
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         ent_rd_ff  <= ent_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
         lv_rd_ff   <= lvalid_ff[rd_addr];
         raddr_ff   <= rd_addr;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: hw/rtl/chained_hash_table_engine_top.sv
`timescale 1ns / 1ps
// Path: a request passes the front stages and the queue; the back end sets
// up, walks the chain with one memory read per slot visited, then updates
// and loads the result. Pace: set by that walk; the back end takes a new
// request only when idle, and a list request visits every bucket and stored slot.
// Reset: synchronous, active high; clears buckets, free stack and count at
// once, no clearing pass.
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top: chained hash table engine
// Front end classifies requests, a short queue decouples it from the back
// end that walks and edits the chains and emits result words.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   // key[63:0], key_length[67:64], phone[107:68], code[123:108]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], location[7:3], found_phone[47:8], found_code[63:48],
   // found_key[127:64]
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast
);

   logic              fq_valid, fq_ready;
   chte_pkg::cmd_type fq_data;
   logic              qb_valid, qb_ready;
   chte_pkg::cmd_type qb_data;

   chte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_data     (fq_data)
   );

   chte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   chte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (qb_valid),
      .cmd_ready  (qb_ready),
      .cmd        (qb_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/chte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_checker: port-level checks for the chained hash table engine
// Result stream handshake and result word consistency.
// ----------------------------------------------------------------------------
module chte_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast
);

   // stalled word stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // stalled word stays unchanged
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // anything but ok ends its request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != chte_pkg::ST_OK |-> rsp_tlast)
      else $error("non-ok result without last");

   // not-found, full and bad-key results carry no record
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == chte_pkg::ST_NOT_FOUND ||
                     rsp_tdata[2:0] == chte_pkg::ST_FULL ||
                     rsp_tdata[2:0] == chte_pkg::ST_BAD_KEY) |-> rsp_tdata[127:3] == '0)
      else $error("failed result carries record data");

endmodule

bind chained_hash_table_engine_top chte_checker u_chte_checker (.*);
